### sv/icl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package icl_pkg;

   // sample format: unsigned, SAMPLE_FRAC_BITS fraction bits, one integer bit
   localparam int SAMPLE_FRAC_BITS = 16;
   localparam int SW = SAMPLE_FRAC_BITS + 1;
   localparam int TDATA_W = ((SW + 7) / 8) * 8;

   // internal log/exp values are signed Q30 in a WW-bit word
   localparam int Q = 30;
   localparam int WW = 48;
   localparam int KW = WW - Q;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_GAMMA = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_OFFSET = 2'd2;

   localparam logic [2:0] MODE_SURF_GLOBAL = 3'd0;
   localparam logic [2:0] MODE_SEP_GLOBAL = 3'd1;
   localparam logic [2:0] MODE_SURF_LOCAL = 3'd2;
   localparam logic [2:0] MODE_REV_SURF = 3'd3;
   localparam logic [2:0] MODE_REV_SEP = 3'd4;

   localparam logic [15:0] INV_GAMMA_RESET = 16'd26542;
   localparam logic [15:0] INV_OFFSET_RESET = 16'd7905;

   localparam logic [Q-1:0] LN2_Q30 = 30'd744261118;
   localparam logic [Q:0] LOG2E_Q30 = 31'd1549082005;

   // curve constants, unsigned Q16
   localparam logic [16:0] FWD_D_SEP = 17'd15729;
   localparam logic [16:0] FWD_D_LOCAL = 17'd9916;
   localparam logic [19:0] FWD_E_SEP = 20'd342753;
   localparam logic [19:0] FWD_E_LOCAL = 20'd336960;
   localparam logic [16:0] REV_A_SURF = 17'd95683;
   localparam logic [16:0] REV_A_SEP = 17'd85197;
   localparam logic [19:0] REV_B_SURF = 20'd13763;
   localparam logic [19:0] REV_B_SEP = 20'd13107;

   typedef struct packed {
      logic [2:0]           mode;
      logic                 done;
      logic                 clamp;
      logic [SW-1:0]        res;
      logic [SW-1:0]        x;
      logic signed [WW-1:0] w;
   } item_type;

endpackage
`default_nettype wire

### sv/icl_log2.sv
`timescale 1ns / 1ps
`default_nettype none
module icl_log2 (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  icl_pkg::item_type in_item,
   output logic              out_valid,
   output icl_pkg::item_type out_item
);
   import icl_pkg::*;

   localparam int MSB_W = $clog2(WW);
   localparam int STEPS = Q;

   logic [MSB_W-1:0] msb_in;
   logic             a_valid_ff;
   item_type         a_item_ff;
   logic [MSB_W-1:0] a_msb_ff;
   logic [WW-1:0]    shift_in;
   logic [Q:0]       mant_in;

   logic             valid_ff [STEPS+1];
   item_type         item_ff  [STEPS+1];
   logic [MSB_W-1:0] msb_ff   [STEPS+1];
   logic [Q:0]       mant_ff  [STEPS+1];
   logic [Q-1:0]     frac_ff  [STEPS+1];

   // leading one
   always_comb begin
      msb_in = '0;
      for (int i = 0; i < WW; i++) begin
         if (in_item.w[i]) begin
            msb_in = MSB_W'(i);
         end
      end
   end

   // normalize to [1,2) in Q30
   always_comb begin
      if (a_msb_ff >= MSB_W'(Q)) begin
         shift_in = unsigned'(a_item_ff.w) >> (a_msb_ff - MSB_W'(Q));
      end else begin
         shift_in = unsigned'(a_item_ff.w) << (MSB_W'(Q) - a_msb_ff);
      end
      mant_in = shift_in[Q:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         valid_ff[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_item_ff <= in_item;
         a_msb_ff <= msb_in;
         item_ff[0] <= a_item_ff;
         msb_ff[0] <= a_msb_ff;
         mant_ff[0] <= mant_in;
         frac_ff[0] <= '0;
      end
   end

   // one fraction bit per stage by squaring
   for (genvar j = 1; j <= STEPS; j++) begin : g_step
      localparam int BITPOS = STEPS - j;
      logic [2*Q+1:0] sq_in;
      logic [Q+1:0]   top_in;
      logic [Q-1:0]   frac_in;

      always_comb begin
         sq_in = (2*Q+2)'(mant_ff[j-1]) * (2*Q+2)'(mant_ff[j-1]);
         top_in = sq_in[2*Q+1:Q];
         frac_in = frac_ff[j-1];
         if (top_in[Q+1]) begin
            frac_in[BITPOS] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            item_ff[j] <= item_ff[j-1];
            msb_ff[j] <= msb_ff[j-1];
            frac_ff[j] <= frac_in;
            mant_ff[j] <= top_in[Q+1] ? top_in[Q+1:1] : top_in[Q:0];
         end
      end
   end

   // integer part is the raw bit position, the caller removes the format offset
   always_comb begin
      out_valid = valid_ff[STEPS];
      out_item = item_ff[STEPS];
      out_item.w = signed'(WW'({msb_ff[STEPS], frac_ff[STEPS]}));
   end

endmodule
`default_nettype wire

### sv/icl_exp2.sv
`timescale 1ns / 1ps
`default_nettype none
module icl_exp2 (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  icl_pkg::item_type in_item,
   output logic              out_valid,
   output icl_pkg::item_type out_item
);
   import icl_pkg::*;

   localparam int TERMS = 20;
   localparam int RECIP_SH = Q + 5;
   localparam int EW = Q + 11;
   localparam logic [EW-1:0] EXP_CAP = EW'(1) << (Q + 10);
   localparam logic signed [KW-1:0] K_CAP = KW'(10);
   localparam logic signed [KW-1:0] K_MIN = KW'(-40);

   logic signed [KW-1:0] k_in;
   logic                 a_valid_ff;
   item_type             a_item_ff;
   logic signed [KW-1:0] a_k_ff;
   logic [Q-1:0]         a_f_ff;
   logic [2*Q-1:0]       t_prod_in;

   logic                 valid_d [TERMS+1];
   item_type             item_d  [TERMS+1];
   logic signed [KW-1:0] k_d     [TERMS+1];
   logic [Q-1:0]         t_d     [TERMS+1];
   logic [Q:0]           term_d  [TERMS+1];
   logic [Q+1:0]         sum_d   [TERMS+1];

   logic                 valid_m [1:TERMS];
   item_type             item_m  [1:TERMS];
   logic signed [KW-1:0] k_m     [1:TERMS];
   logic [Q-1:0]         t_m     [1:TERMS];
   logic [Q:0]           prod_m  [1:TERMS];
   logic [Q+1:0]         sum_m   [1:TERMS];

   logic [KW-1:0]        nk_in;
   logic [EW-1:0]        ext_in;
   logic [EW-1:0]        r_in;
   logic                 out_valid_ff;
   item_type             out_item_ff;
   logic [EW-1:0]        out_r_ff;

   // integer part rounds toward minus infinity, fraction is what is left
   always_comb begin
      k_in = KW'(in_item.w >>> Q);
      t_prod_in = (2*Q)'(a_f_ff) * (2*Q)'(LN2_Q30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         valid_d[0] <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         valid_d[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_item_ff <= in_item;
         a_k_ff <= k_in;
         a_f_ff <= in_item.w[Q-1:0];
         item_d[0] <= a_item_ff;
         k_d[0] <= a_k_ff;
         t_d[0] <= t_prod_in[2*Q-1:Q];
         term_d[0] <= (Q+1)'(1) << Q;
         sum_d[0] <= (Q+2)'(1) << Q;
      end
   end

   // taylor series of e^t, one multiply stage and one divide stage per term
   for (genvar n = 1; n <= TERMS; n++) begin : g_term
      localparam logic [RECIP_SH:0] RECIP =
         (RECIP_SH+1)'(((64'd1 << RECIP_SH) + 64'(n) - 64'd1) / 64'(n));
      logic [2*Q:0]          mul_in;
      logic [RECIP_SH+Q+1:0] div_in;
      logic [Q:0]            quo_in;

      always_comb begin
         mul_in = (2*Q+1)'(term_d[n-1]) * (2*Q+1)'(t_d[n-1]);
         div_in = (RECIP_SH+Q+2)'(prod_m[n]) * (RECIP_SH+Q+2)'(RECIP);
         quo_in = div_in[RECIP_SH+Q:RECIP_SH];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_m[n] <= 1'b0;
            valid_d[n] <= 1'b0;
         end else if (en) begin
            valid_m[n] <= valid_d[n-1];
            valid_d[n] <= valid_m[n];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            item_m[n] <= item_d[n-1];
            k_m[n] <= k_d[n-1];
            t_m[n] <= t_d[n-1];
            sum_m[n] <= sum_d[n-1];
            prod_m[n] <= mul_in[2*Q:Q];
            item_d[n] <= item_m[n];
            k_d[n] <= k_m[n];
            t_d[n] <= t_m[n];
            term_d[n] <= quo_in;
            sum_d[n] <= sum_m[n] + (Q+2)'(quo_in);
         end
      end
   end

   // scale by 2^k, saturate high, flush low
   always_comb begin
      nk_in = unsigned'(-k_d[TERMS]);
      ext_in = EW'(sum_d[TERMS]);
      if (k_d[TERMS] >= K_CAP) begin
         r_in = EXP_CAP;
      end else if (k_d[TERMS] >= KW'(0)) begin
         r_in = ext_in << k_d[TERMS][3:0];
      end else if (k_d[TERMS] <= K_MIN) begin
         r_in = '0;
      end else begin
         r_in = ext_in >> nk_in[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_d[TERMS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_item_ff <= item_d[TERMS];
         out_r_ff <= r_in;
      end
   end

   always_comb begin
      out_valid = out_valid_ff;
      out_item = out_item_ff;
      out_item.w = signed'(WW'(out_r_ff));
   end

endmodule
`default_nettype wire

### sv/intensity_curve_linearizer.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  req_tdata: sample_in
// rsp       out  rsp_tvalid/rsp_tready  rsp_tdata: sample_out, rsp_tuser: was_clamped
// csr       in   csr_valid/csr_ready    csr_index, csr_wdata
//
// one transaction per cycle sustained while rsp is not stalled
// the datapath holds two log2 units (32 stages each, one fraction bit per
// squaring stage) and two exp2 units (43 stages each, two stages per series term)
// synchronous active-high reset clears valid bits and loads the csr defaults
// a stalled rsp freezes the whole pipeline in place; req_tready follows it
module intensity_curve_linearizer (
   input  logic                                clock,
   input  logic                                reset,
   // req transaction
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [icl_pkg::TDATA_W-1:0]         req_tdata,   // [16:0] sample_in
   // rsp transaction
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [icl_pkg::TDATA_W-1:0]         rsp_tdata,   // [16:0] sample_out
   output logic                                rsp_tuser,   // [0] was_clamped
   // csr write transaction
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [icl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [icl_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import icl_pkg::*;

   localparam logic [WW-1:0] Q_ONE = WW'(1) << Q;
   localparam logic [WW-1:0] ONE_W = WW'(1) << SAMPLE_FRAC_BITS;
   localparam logic [SW-1:0] SAMPLE_ONE = SW'(1) << SAMPLE_FRAC_BITS;
   localparam int OUT_SH = Q - SAMPLE_FRAC_BITS;

   logic        en;
   logic [2:0]  mode_ff;
   logic [15:0] inv_gamma_ff;
   logic [15:0] inv_offset_ff;

   item_type s0_in, s1_in, s2_in, s3_in, s4_in, s5_in, s6_in, s7_in, s8_in, s9_in;
   item_type s0_ff, s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff, s8_ff, s9_ff;
   logic     s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic     s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff, s9_valid_ff;

   logic     e1_valid, l1_valid, e2_valid, l2_valid;
   item_type e1_item, l1_item, e2_item, l2_item;

   // stage scratch
   logic [Q:0]        s1_xq;
   logic [2*Q+1:0]    s1_prod;
   logic [WW-1:0]     s2_u;
   logic [WW-1:0]     s3_fb;
   logic [WW-1:0]     s4_mag;
   logic [19:0]       s4_coef;
   logic [WW+19:0]    s4_prod;
   logic [WW-1:0]     s4_scaled;
   logic [16:0]       s5_coef;
   logic [WW+16:0]    s5_prod;
   logic [WW-1:0]     s6_r;
   logic [WW+Q-1:0]   s8_prod;
   logic [WW-1:0]     s9_r;

   // whole pipeline advances unless a result is held at the output
   assign en = !s9_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SURF_GLOBAL;
         inv_gamma_ff <= INV_GAMMA_RESET;
         inv_offset_ff <= INV_OFFSET_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CURVE_MODE: mode_ff <= csr_wdata[2:0];
            CSR_INV_GAMMA: inv_gamma_ff <= csr_wdata;
            CSR_INV_OFFSET: inv_offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // s0: capture, undefined modes and zero input finish here
   always_comb begin
      s0_in.mode = mode_ff;
      s0_in.x = req_tdata[SW-1:0];
      s0_in.clamp = 1'b0;
      s0_in.w = '0;
      s0_in.done = (mode_ff > MODE_REV_SEP) || (req_tdata[SW-1:0] == '0);
      s0_in.res = (mode_ff > MODE_REV_SEP) ? req_tdata[SW-1:0] : '0;
   end

   // s1: I * log2(e) for the exponential forward curves
   always_comb begin
      s1_in = s0_ff;
      s1_xq = (Q+1)'(s0_ff.x) << OUT_SH;
      s1_prod = (2*Q+2)'(s1_xq) * (2*Q+2)'(LOG2E_Q30);
      s1_in.w = signed'(WW'(s1_prod[2*Q+1:Q]));
   end

   icl_exp2 u_e1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_item   (s1_ff),
      .out_valid (e1_valid),
      .out_item  (e1_item)
   );

   // s2: e^I - 1, or pick the raw sample for the power curves
   always_comb begin
      s2_in = e1_item;
      s2_u = unsigned'(e1_item.w) - Q_ONE;
      if (e1_item.mode == MODE_SEP_GLOBAL || e1_item.mode == MODE_SURF_LOCAL) begin
         s2_in.w = signed'(s2_u);
         if (!e1_item.done && s2_u == '0) begin
            s2_in.done = 1'b1;
            s2_in.res = '0;
         end
      end else begin
         s2_in.w = signed'(WW'(e1_item.x));
      end
   end

   icl_log2 u_l1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .in_item   (s2_ff),
      .out_valid (l1_valid),
      .out_item  (l1_item)
   );

   // s3: remove the fixed-point offset from the log
   always_comb begin
      s3_in = l1_item;
      if (l1_item.mode == MODE_SEP_GLOBAL || l1_item.mode == MODE_SURF_LOCAL) begin
         s3_fb = WW'(Q) << Q;
      end else begin
         s3_fb = WW'(SAMPLE_FRAC_BITS) << Q;
      end
      s3_in.w = l1_item.w - signed'(s3_fb);
   end

   // s4: exponent scaling, sign-magnitude so the product truncates toward zero
   always_comb begin
      s4_in = s3_ff;
      s4_mag = s3_ff.w[WW-1] ? unsigned'(-s3_ff.w) : unsigned'(s3_ff.w);
      unique case (s3_ff.mode)
         MODE_SURF_GLOBAL: s4_coef = 20'(inv_gamma_ff);
         MODE_SEP_GLOBAL: s4_coef = FWD_E_SEP;
         MODE_SURF_LOCAL: s4_coef = FWD_E_LOCAL;
         MODE_REV_SURF: s4_coef = REV_B_SURF;
         MODE_REV_SEP: s4_coef = REV_B_SEP;
         default: s4_coef = '0;
      endcase
      s4_prod = (WW+20)'(s4_mag) * (WW+20)'(s4_coef);
      if (s3_ff.mode == MODE_SURF_GLOBAL) begin
         s4_scaled = WW'(s4_prod >> 12);
      end else begin
         s4_scaled = WW'(s4_prod >> 16);
      end
      s4_in.w = s3_ff.w[WW-1] ? -signed'(s4_scaled) : signed'(s4_scaled);
   end

   icl_exp2 u_e2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .in_item   (s4_ff),
      .out_valid (e2_valid),
      .out_item  (e2_item)
   );

   // s5: output gain for forward curves, A * I^B for reverse curves
   always_comb begin
      s5_in = e2_item;
      unique case (e2_item.mode)
         MODE_SURF_GLOBAL: s5_coef = 17'(inv_offset_ff);
         MODE_SEP_GLOBAL: s5_coef = FWD_D_SEP;
         MODE_SURF_LOCAL: s5_coef = FWD_D_LOCAL;
         MODE_REV_SURF: s5_coef = REV_A_SURF;
         MODE_REV_SEP: s5_coef = REV_A_SEP;
         default: s5_coef = '0;
      endcase
      s5_prod = (WW+17)'(unsigned'(e2_item.w)) * (WW+17)'(s5_coef);
      if (e2_item.mode == MODE_SURF_GLOBAL) begin
         s5_in.w = signed'(WW'(s5_prod >> 12));
      end else begin
         s5_in.w = signed'(WW'(s5_prod >> 16));
      end
   end

   // s6: forward curves clamp and finish, reverse curves form 1 + A * I^B
   always_comb begin
      s6_in = s5_ff;
      s6_r = unsigned'(s5_ff.w) >> OUT_SH;
      if (s5_ff.mode == MODE_REV_SURF || s5_ff.mode == MODE_REV_SEP) begin
         s6_in.w = signed'(Q_ONE + unsigned'(s5_ff.w));
      end else if (!s5_ff.done) begin
         s6_in.done = 1'b1;
         if (s6_r > ONE_W) begin
            s6_in.res = SAMPLE_ONE;
            s6_in.clamp = 1'b1;
         end else begin
            s6_in.res = s6_r[SW-1:0];
         end
      end
   end

   icl_log2 u_l2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_valid_ff),
      .in_item   (s6_ff),
      .out_valid (l2_valid),
      .out_item  (l2_item)
   );

   // s7: log2 of a Q30 value
   always_comb begin
      s7_in = l2_item;
      s7_in.w = l2_item.w - signed'(WW'(Q) << Q);
   end

   // s8: natural log from log2, log2 of 1 + A * I^B stays below 2^34
   always_comb begin
      s8_in = s7_ff;
      s8_prod = (WW+Q)'(s7_ff.w[34:0]) * (WW+Q)'(LN2_Q30);
      s8_in.w = signed'(WW'(s8_prod >> Q));
   end

   // s9: reverse curves saturate at one, no flag
   always_comb begin
      s9_in = s8_ff;
      s9_r = unsigned'(s8_ff.w) >> OUT_SH;
      if (!s8_ff.done) begin
         s9_in.done = 1'b1;
         s9_in.res = (s9_r > ONE_W) ? SAMPLE_ONE : s9_r[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= e1_valid;
         s3_valid_ff <= l1_valid;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= e2_valid;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= l2_valid;
         s8_valid_ff <= s7_valid_ff;
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         s8_ff <= s8_in;
         s9_ff <= s9_in;
      end
   end

   assign rsp_tvalid = s9_valid_ff;
   assign rsp_tdata = TDATA_W'(s9_ff.res);
   assign rsp_tuser = s9_ff.clamp;

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import icl_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 200;       // margin beyond the req-to-rsp pipeline depth
   localparam int ITEMS_PER_PHASE = 152;
   localparam int NUM_PHASES = 12;
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [16:0] MAX_SAMPLE = 17'h1FFFF;
   // codes 5..7 have no curve, the block passes the sample through
   localparam logic [2:0] MODE_PASS_LO = 3'd5;
   localparam logic [2:0] MODE_PASS_HI = 3'd7;

   typedef struct {
      logic [2:0]  mode;
      logic [15:0] gamma;
      logic [15:0] offset;
   } curve_setting;

   // reference curve and queue of expected mapped samples
   class curve_scoreboard;
      typedef struct {
         logic [16:0] sample;
         logic        clamped;
      } mapped_sample;

      logic [2:0]  mode;
      logic [15:0] inv_gamma;
      logic [15:0] inv_offset;
      mapped_sample pending_q[$];
      int mismatches;
      int results_seen;

      function new();
         mode = MODE_SURF_GLOBAL;
         inv_gamma = INV_GAMMA_RESET;
         inv_offset = INV_OFFSET_RESET;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
         case (idx)
            CSR_CURVE_MODE: mode = val[2:0];
            CSR_INV_GAMMA: inv_gamma = val;
            CSR_INV_OFFSET: inv_offset = val;
            default: ;
         endcase
      endfunction

      // base-2 log of x with fb fraction bits, signed Q30
      function longint log2_fix(longint unsigned x, int fb);
         int p;
         longint unsigned m;
         longint frac;
         p = 0;
         frac = 0;
         while (p < 63 && (x >> (p + 1)) != 0) p++;
         if (p >= 30) m = x >> (p - 30);
         else m = x << (30 - p);
         for (int i = 29; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
               m = m >> 1;
               frac = frac | (64'sd1 << i);
            end
         end
         return (longint'(p) - longint'(fb)) * 64'sd1073741824 + frac;
      endfunction

      // 2^y for signed Q30 y, saturating at 1024.0
      function longint unsigned exp2_fix(longint y);
         longint k;
         longint unsigned f, t, term, sum;
         if (y >= 0) k = y >>> 30;
         else k = -((-y + 64'sd1073741823) >>> 30);
         f = longint'(y - k * 64'sd1073741824);
         t = (f * 64'(LN2_Q30)) >> 30;
         sum = 64'd1 << 30;
         term = 64'd1 << 30;
         for (int n = 1; n <= 20; n++) begin
            term = ((term * t) >> 30) / longint'(n);
            sum += term;
         end
         if (k >= 10) return 64'd1 << 40;
         if (k >= 0) return sum << k;
         if (-k >= 40) return 0;
         return sum >> (-k);
      endfunction

      // signed times unsigned with a right shift, truncated toward zero
      function longint scale_fix(longint a, longint unsigned c, int sh);
         longint unsigned mag;
         longint r;
         mag = (a < 0) ? longint'(-a) : a;
         r = longint'((mag * c) >> sh);
         return (a < 0) ? -r : r;
      endfunction

      function mapped_sample map_sample(logic [16:0] x);
         mapped_sample res;
         longint unsigned r, v, r30, xq, ex, u, p, q, fd, fe, ra, rb;
         longint lg;
         res.clamped = 1'b0;
         r = 0;
         if (mode > MODE_REV_SEP) begin
            r = x;
         end else if (x == 0) begin
            r = 0;
         end else if (mode == MODE_SURF_GLOBAL) begin
            lg = log2_fix(x, SAMPLE_FRAC_BITS);
            v = exp2_fix(scale_fix(lg, inv_gamma, 12));
            r30 = (v * inv_offset) >> 12;
            r = r30 >> (30 - SAMPLE_FRAC_BITS);
         end else if (mode <= MODE_SURF_LOCAL) begin
            fd = (mode == MODE_SEP_GLOBAL) ? FWD_D_SEP : FWD_D_LOCAL;
            fe = (mode == MODE_SEP_GLOBAL) ? FWD_E_SEP : FWD_E_LOCAL;
            xq = longint'(x) << (30 - SAMPLE_FRAC_BITS);
            ex = exp2_fix(longint'((xq * 64'(LOG2E_Q30)) >> 30));
            u = ex - (64'd1 << 30);
            // e^I - 1 lost entirely in Q30
            if (u != 0) begin
               lg = log2_fix(u, 30);
               v = exp2_fix(scale_fix(lg, fe, 16));
               r30 = (v * fd) >> 16;
               r = r30 >> (30 - SAMPLE_FRAC_BITS);
            end
         end else begin
            ra = (mode == MODE_REV_SURF) ? REV_A_SURF : REV_A_SEP;
            rb = (mode == MODE_REV_SURF) ? REV_B_SURF : REV_B_SEP;
            lg = log2_fix(x, SAMPLE_FRAC_BITS);
            p = exp2_fix(scale_fix(lg, rb, 16));
            q = (64'd1 << 30) + ((p * ra) >> 16);
            lg = log2_fix(q, 30);
            r30 = (longint'(lg) * 64'(LN2_Q30)) >> 30;
            r = r30 >> (30 - SAMPLE_FRAC_BITS);
            // reverse curves saturate without the flag
            if (r > ONE_Q16) r = ONE_Q16;
         end
         if (mode <= MODE_SURF_LOCAL && r > ONE_Q16) begin
            r = ONE_Q16;
            res.clamped = 1'b1;
         end
         res.sample = r[16:0];
         return res;
      endfunction

      function void note_sample(logic [16:0] x);
         pending_q.push_back(map_sample(x));
      endfunction

      function void check_result(logic [16:0] sample, logic clamped);
         mapped_sample exp_res;
         results_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("error: unexpected rsp transaction sample_out=%0d was_clamped=%0b",
                        sample, clamped);
            return;
         end
         exp_res = pending_q.pop_front();
         if (sample !== exp_res.sample || clamped !== exp_res.clamped) begin
            mismatches++;
            if (mismatches <= 10)
               $display("error: rsp #%0d sample_out exp %0d got %0d, was_clamped exp %0b got %0b",
                        results_seen, exp_res.sample, sample, exp_res.clamped, clamped);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [TDATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   curve_scoreboard curve_sb;
   int tx_idle_pct;
   int rx_idle_pct;
   int cycle_count;
   int samples_sent;
   curve_setting phase_table [NUM_PHASES];

   intensity_curve_linearizer uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver backpressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // rsp transaction monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         curve_sb.check_result(rsp_tdata[SW-1:0], rsp_tuser);
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      curve_sb.set_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   // one req transaction, with an optional gap in front
   task automatic send_sample(logic [16:0] x);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(TDATA_W - SW){1'b0}}, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      curve_sb.note_sample(x);
      samples_sent++;
   endtask

   // mostly in-range intensities, with small, unity and over-range ones mixed in
   function automatic logic [16:0] random_sample();
      case ($urandom_range(9))
         6: return 17'($urandom_range(255, 1));
         7: return ONE_Q16;
         8: return 17'($urandom_range(1));
         9: return 17'($urandom_range(131071));
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (curve_sb.pending_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      curve_sb = new();
      cycle_count = 0;
      samples_sent = 0;
      tx_idle_pct = 11;
      rx_idle_pct = 63;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_CURVE_MODE;
      csr_wdata = '0;

      // phase 0 keeps the reset calibration, the others cover every curve,
      // the pass-through codes and the register extremes
      phase_table[0] = '{MODE_SURF_GLOBAL, INV_GAMMA_RESET, INV_OFFSET_RESET};
      phase_table[1] = '{MODE_SURF_GLOBAL, 16'hFFFF, 16'hFFFF};
      phase_table[2] = '{MODE_SURF_GLOBAL, 16'h0000, 16'd4096};
      phase_table[3] = '{MODE_SEP_GLOBAL, 16'd4096, 16'd4096};
      phase_table[4] = '{MODE_SURF_LOCAL, 16'd8192, 16'd2048};
      phase_table[5] = '{MODE_REV_SURF, 16'd1234, 16'd9999};
      phase_table[6] = '{MODE_REV_SEP, 16'd4096, 16'd4096};
      phase_table[7] = '{MODE_PASS_HI, 16'd4096, 16'd4096};
      phase_table[8] = '{MODE_SURF_GLOBAL, 16'd4096, 16'h0000};
      phase_table[9] = '{MODE_PASS_LO, 16'd100, 16'd100};
      phase_table[10] = '{MODE_SURF_GLOBAL, 16'($urandom), 16'($urandom_range(16384))};
      phase_table[11] = '{MODE_SEP_GLOBAL, 16'($urandom), 16'($urandom)};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // idle profile: sender light and receiver heavy, then swapped, then none
         if (ph < 4) begin
            tx_idle_pct = 11;
            rx_idle_pct = 63;
         end else if (ph < 8) begin
            tx_idle_pct = 63;
            rx_idle_pct = 11;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         if (ph != 0) begin
            drain_pipeline();
            write_csr(CSR_CURVE_MODE, {13'd0, phase_table[ph].mode});
            write_csr(CSR_INV_GAMMA, phase_table[ph].gamma);
            write_csr(CSR_INV_OFFSET, phase_table[ph].offset);
         end
         // zero, unity and the largest code are checked on every curve
         send_sample('0);
         send_sample(ONE_Q16);
         send_sample(MAX_SAMPLE);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_sample(random_sample());
      end

      drain_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (curve_sb.pending_q.size() != 0) begin
         curve_sb.mismatches++;
         $display("error: %0d expected rsp transactions never arrived",
                  curve_sb.pending_q.size());
      end

      $display("covered %0d samples over %0d register settings, all five curves and pass-through",
               samples_sent, NUM_PHASES);
      $display("%0d results checked, %0d mismatches", curve_sb.results_seen,
               curve_sb.mismatches);
      if (curve_sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
sv/icl_pkg.sv
sv/icl_log2.sv
sv/icl_exp2.sv
sv/intensity_curve_linearizer.sv
tb/testbench.sv
